>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the ranger unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold at every clock edge at which the antecedent holds.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> sv/utr_pkg.sv
// Package of types and constants for the three-channel ultrasonic ranger unit.
`default_nettype none

package utr_pkg;

	localparam int unsigned TIMER_BITS_DEF = 16;

	localparam int unsigned CFG_W = 8;
	localparam int unsigned CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCAN_PERIOD  = 1'b0,
		CFG_US_PER_COUNT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SENSOR_LEFT  = 2'd0,
		SENSOR_FRONT = 2'd1,
		SENSOR_RIGHT = 2'd2
	} sensor_t;

	localparam logic [CFG_W-1:0] SCAN_PERIOD_RST  = 8'd60;
	localparam logic [CFG_W-1:0] US_PER_COUNT_RST = 8'd64;
	localparam logic [7:0]       MS_COUNT_MAX     = 8'd255;

	localparam int unsigned DIST_W     = 16;
	localparam int unsigned CM_DIVISOR = 58;

	// Anything at or above this many microseconds saturates the distance.
	localparam logic [31:0] CM_SAT_LIMIT = 32'(CM_DIVISOR * (2 ** DIST_W));

	// Below the limit, us fits in 22 bits; divide us/2 by 29 with a reciprocal.
	localparam int unsigned CM_HALF_DIV = CM_DIVISOR / 2;
	localparam int unsigned CM_Y_W      = 21;
	localparam int unsigned RECIP_W     = 22;
	localparam int unsigned RECIP_SHIFT = 26;
	localparam logic [RECIP_W-1:0] CM_RECIP = RECIP_W'(
		((64'd1 << RECIP_SHIFT) + 64'(CM_HALF_DIV) - 64'd1) / 64'(CM_HALF_DIV));

endpackage

`default_nettype wire

>>> sv/ultrasonic_three_channel_ranger_unit.sv
// Top level of the three-channel ultrasonic ranger: trigger sequencing and echo timing.
`default_nettype none

// Takes one sample beat per clock while the output is not stalled and returns
// one result beat per sample. A sample passes an input register, then one pass
// of logic updates the trigger sequencer, the echo timer and the distances and
// loads the result register. The echo timer is multiplied by us_per_count as
// it is written, so the pass itself only holds the reciprocal multiply that
// divides by 58; that multiply sets the clock. Configuration writes take effect
// on the next clock and belong to idle time. The distance outputs hold the
// stored distances of the beat on offer.
`include "assert_macros.svh"

module ultrasonic_three_channel_ranger_unit
	import utr_pkg::*;
#(
	parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,

	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 ms_tick,
	input  wire logic                 timer_tick,
	input  wire logic [2:0]           echo_levels,

	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [2:0]                trigger_onehot,
	output logic [DIST_W-1:0]         dist_left_cm,
	output logic [DIST_W-1:0]         dist_front_cm,
	output logic [DIST_W-1:0]         dist_right_cm,
	output logic                      report
);

	localparam int unsigned PROD_W = TIMER_BITS + CFG_W;

	// configuration
	logic [CFG_W-1:0] scan_period_q, us_per_count_q, us_per_count_d;

	// input stage
	logic       valid_s1, ms_tick_s1, timer_tick_s1;
	logic [2:0] echo_s1;

	// result stage
	logic       valid_s2, report_s2;
	logic [2:0] trig_s2;

	// block state
	logic [2:0]            prev_echo_q;
	logic [TIMER_BITS-1:0] timer_q, timer_next, timer_d;
	logic [7:0]            ms_count_q, ms_inc, ms_next;
	sensor_t               sensor_q, sensor_next;
	logic [DIST_W-1:0]     dist_q [3];
	logic [PROD_W-1:0]     prod_q, prod_d;

	logic                          advance, load, fire, rpt;
	logic [2:0]                    trig, rise, fall;
	logic [31:0]                   us_val;
	logic [CM_Y_W+RECIP_W-1:0]     quo_prod;
	logic [DIST_W-1:0]             cm;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_comb begin
		ms_inc = ms_count_q;
		if (ms_tick_s1 && ms_count_q != MS_COUNT_MAX) begin
			ms_inc = ms_count_q + 8'd1;
		end
		fire        = ms_inc >= scan_period_q;
		ms_next     = fire ? 8'd0 : ms_inc;
		trig        = 3'b000;
		rpt         = 1'b0;
		sensor_next = sensor_q;
		if (fire) begin
			case (sensor_q)
				SENSOR_FRONT: begin
					trig        = 3'b010;
					sensor_next = SENSOR_RIGHT;
				end
				SENSOR_RIGHT: begin
					trig        = 3'b100;
					rpt         = 1'b1;
					sensor_next = SENSOR_LEFT;
				end
				default: begin
					trig        = 3'b001;
					sensor_next = SENSOR_FRONT;
				end
			endcase
		end

		rise = echo_s1 & ~prev_echo_q;
		fall = ~echo_s1 & prev_echo_q;
		if (|rise) begin
			timer_next = '0;
		end else if (timer_tick_s1) begin
			timer_next = timer_q + TIMER_BITS'(1);
		end else begin
			timer_next = timer_q;
		end
		timer_d = advance ? timer_next : timer_q;

		us_per_count_d = us_per_count_q;
		if (cfg_wr_en && cfg_index == CFG_US_PER_COUNT) begin
			us_per_count_d = cfg_data;
		end
		prod_d = PROD_W'(timer_d) * PROD_W'(us_per_count_d);

		// prod_q holds timer_q * us_per_count_q: microseconds of the current count
		us_val   = 32'(prod_q);
		quo_prod = (CM_Y_W+RECIP_W)'(us_val[CM_Y_W:1]) * (CM_Y_W+RECIP_W)'(CM_RECIP);
		if (us_val >= CM_SAT_LIMIT) begin
			cm = '1;
		end else begin
			cm = quo_prod[RECIP_SHIFT+DIST_W-1:RECIP_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q  <= SCAN_PERIOD_RST;
			us_per_count_q <= US_PER_COUNT_RST;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			trig_s2        <= 3'b000;
			report_s2      <= 1'b0;
			prev_echo_q    <= 3'b000;
			timer_q        <= '0;
			ms_count_q     <= 8'd0;
			sensor_q       <= SENSOR_LEFT;
			prod_q         <= '0;
			for (int i = 0; i < 3; i++) begin
				dist_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en && cfg_index == CFG_SCAN_PERIOD) begin
				scan_period_q <= cfg_data;
			end
			us_per_count_q <= us_per_count_d;
			timer_q        <= timer_d;
			prod_q         <= prod_d;

			if (load) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				valid_s2    <= 1'b1;
				trig_s2     <= trig;
				report_s2   <= rpt;
				prev_echo_q <= echo_s1;
				ms_count_q  <= ms_next;
				sensor_q    <= sensor_next;
				for (int i = 0; i < 3; i++) begin
					if (fall[i]) begin
						dist_q[i] <= cm;
					end
				end
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ms_tick_s1    <= ms_tick;
			timer_tick_s1 <= timer_tick;
			echo_s1       <= echo_levels;
		end
	end

	assign out_valid      = valid_s2;
	assign trigger_onehot = trig_s2;
	assign report         = report_s2;
	assign dist_left_cm   = dist_q[0];
	assign dist_front_cm  = dist_q[1];
	assign dist_right_cm  = dist_q[2];

	`ASSERT_ALWAYS(a_prod_tracks_timer, prod_q == PROD_W'(timer_q) * PROD_W'(us_per_count_q), "product register out of step with echo timer")
	`ASSERT_IMPLIES(a_report_on_right, out_valid && report, trigger_onehot == 3'b100, "report without right trigger")
	`ASSERT_IMPLIES(a_stall_holds_stage, in_stall, valid_s1 && valid_s2 && out_stall, "input stalled with room downstream")

endmodule

`default_nettype wire
